// File: sv/assert_macros.svh
// Assertion helper macros for the accessory classifier RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/uidac_pkg.sv
// Shared types and constants for the USB ID accessory classifier.
// No dependencies; imported by uidac_step and the top level.
`timescale 1ns / 1ps

package uidac_pkg;

  // Accessory and dock switch encoding
  typedef enum logic [2:0] {
    ACC_UNDOCKED = 3'd0,
    ACC_DESK     = 3'd1,
    ACC_CAR      = 3'd2,
    ACC_HEADSET  = 3'd3,
    ACC_DMB      = 3'd4,
    ACC_MHL      = 3'd5,
    ACC_HOST     = 3'd6,
    ACC_UNDEF    = 3'd7
  } acc_t;

  // Audio path actions
  localparam logic [1:0] AUDIO_NONE      = 2'd0;
  localparam logic [1:0] AUDIO_USB_AUDIO = 2'd1;
  localparam logic [1:0] AUDIO_USB       = 2'd2;

  // Host notify actions
  localparam logic [1:0] HOST_NONE       = 2'd0;
  localparam logic [1:0] HOST_CONNECT    = 2'd1;
  localparam logic [1:0] HOST_DISCONNECT = 2'd2;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_STABLE_NEEDED = 3'd0;
  localparam logic [2:0] REG_ADC_MODE      = 3'd1;
  localparam logic [2:0] REG_SECOND_PROBE  = 3'd2;
  localparam logic [2:0] REG_MHL_SUPPORTED = 3'd3;
  localparam logic [2:0] REG_HOST_SUPPORTED = 3'd4;

  // Resistor windows of the first reading
  localparam logic [11:0] ADC_SECOND_HI  = 12'd150;
  localparam logic [11:0] ADC_CAR_HI     = 12'd220;
  localparam logic [11:0] ADC_HEADSET_LO = 12'd370;
  localparam logic [11:0] ADC_DMB_LO     = 12'd440;
  localparam logic [11:0] ADC_DESK_LO    = 12'd550;
  localparam logic [11:0] ADC_DESK_HI    = 12'd620;
  // Inclusive MHL window of the second reading
  localparam logic [11:0] ADC_MHL_LO     = 12'd770;
  localparam logic [11:0] ADC_MHL_HI     = 12'd1020;

  typedef struct packed {
    logic [3:0] stable_needed;
    logic       adc_mode;
    logic       second_probe_present;
    logic       mhl_supported;
    logic       host_supported;
  } cfg_t;

  typedef struct packed {
    logic        id_level;
    logic        redetect;
    logic [11:0] adc_first;
    logic [11:0] adc_second;
  } item_t;

  typedef struct packed {
    acc_t       last_class;
    logic [3:0] same_count;
    acc_t       current_accessory;
  } state_t;

  typedef struct packed {
    logic       settled;
    acc_t       accessory;
    logic       switch_update;
    acc_t       switch_value;
    logic [1:0] audio_path;
    logic [1:0] host_notify;
    logic       charge_clear;
    logic       irq_rearm;
    logic       irq_trigger_high;
  } result_t;

endpackage

// File: sv/usb_id_accessory_classifier_top.sv
// USB ID accessory classifier: input register, step logic, result register
// and the configuration registers. Depends on uidac_pkg, uidac_step and
// assert_macros.svh.
// A word accepted into the input register passes through the step logic
// and the result register before it appears on the out_ ports.
// Throughput: one word per cycle while out_stall is low; the classify/count/act
// logic between the two registers is the only path and the run state updates as a word moves.
// Reset (rst_n low, synchronous): pipeline empty, run state cleared to
// undocked, registers back to stable_needed 3 and all enables set.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usb_id_accessory_classifier_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_id_level,
  input  logic        in_redetect,
  input  logic [11:0] in_adc_first,
  input  logic [11:0] in_adc_second,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_settled,
  output logic [2:0]  out_accessory,
  output logic        out_switch_update,
  output logic [2:0]  out_switch_value,
  output logic [1:0]  out_audio_path,
  output logic [1:0]  out_host_notify,
  output logic        out_charge_clear,
  output logic        out_irq_rearm,
  output logic        out_irq_trigger_high,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import uidac_pkg::*;

  cfg_t    cfg_r;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    out_load;
  logic    in_take;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_needed        <= 4'd3;
      cfg_r.adc_mode             <= 1'b1;
      cfg_r.second_probe_present <= 1'b1;
      cfg_r.mhl_supported        <= 1'b1;
      cfg_r.host_supported       <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_STABLE_NEEDED:  cfg_r.stable_needed        <= pwdata[3:0];
        REG_ADC_MODE:       cfg_r.adc_mode             <= pwdata[0];
        REG_SECOND_PROBE:   cfg_r.second_probe_present <= pwdata[0];
        REG_MHL_SUPPORTED:  cfg_r.mhl_supported        <= pwdata[0];
        REG_HOST_SUPPORTED: cfg_r.host_supported       <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_STABLE_NEEDED:  prdata[3:0] = cfg_r.stable_needed;
      REG_ADC_MODE:       prdata[0]   = cfg_r.adc_mode;
      REG_SECOND_PROBE:   prdata[0]   = cfg_r.second_probe_present;
      REG_MHL_SUPPORTED:  prdata[0]   = cfg_r.mhl_supported;
      REG_HOST_SUPPORTED: prdata[0]   = cfg_r.host_supported;
      default:            prdata      = '0;
    endcase
  end

  // Handshake: result register loads when empty or being taken
  assign out_load = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (out_load) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.id_level   <= in_id_level;
      item_r.redetect   <= in_redetect;
      item_r.adc_first  <= in_adc_first;
      item_r.adc_second <= in_adc_second;
    end
  end

  uidac_step u_step (
    .cfg       (cfg_r),
    .item      (item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  // Run state advances as a word moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_class        <= ACC_UNDOCKED;
      state_r.same_count        <= 4'd0;
      state_r.current_accessory <= ACC_UNDOCKED;
    end else if (out_load) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_settled          = res_r.settled;
  assign out_accessory        = res_r.accessory;
  assign out_switch_update    = res_r.switch_update;
  assign out_switch_value     = res_r.switch_value;
  assign out_audio_path       = res_r.audio_path;
  assign out_host_notify      = res_r.host_notify;
  assign out_charge_clear     = res_r.charge_clear;
  assign out_irq_rearm        = res_r.irq_rearm;
  assign out_irq_trigger_high = res_r.irq_trigger_high;

  // A held result always matches the accessory state
  `ASSERT_IMPLIES(a_acc_tracks_state, clk, rst_n, out_valid_r, res_r.accessory == state_r.current_accessory, "result accessory differs from state")
  // MHL never re-arms the ID interrupt
  `ASSERT_IMPLIES(a_mhl_no_rearm, clk, rst_n, out_valid_r && res_r.accessory == ACC_MHL, !res_r.irq_rearm, "interrupt re-armed while MHL")
  // Retry carries no actions
  `ASSERT_IMPLIES(a_retry_quiet, clk, rst_n, out_valid_r && !res_r.settled, !res_r.switch_update && !res_r.irq_rearm && res_r.audio_path == AUDIO_NONE && res_r.host_notify == HOST_NONE && !res_r.charge_clear, "retry with actions")
  // A full input register behind a stalled result holds its word
  `ASSERT_NEXT(a_hold_when_full, clk, rst_n, item_valid_r && out_valid_r && out_stall, item_valid_r, "input word dropped under stall")

endmodule

// File: sv/uidac_step.sv
// Combinational step: classify one sample, advance the run counter and
// decode the accessory actions. Depends on uidac_pkg.
`timescale 1ns / 1ps

module uidac_step (
  input  uidac_pkg::cfg_t    cfg,
  input  uidac_pkg::item_t   item,
  input  uidac_pkg::state_t  state,
  output uidac_pkg::state_t  state_nxt,
  output uidac_pkg::result_t res
);
  import uidac_pkg::*;

  acc_t       second_cls;
  acc_t       cls;
  acc_t       acc_nxt;
  logic       mhl_hit;
  logic [3:0] count_base;
  logic [3:0] count_nxt;
  logic       retry;

  // Resolve the lowest window with the second reading
  always_comb begin
    mhl_hit = cfg.second_probe_present &&
              (item.adc_second >= ADC_MHL_LO) && (item.adc_second <= ADC_MHL_HI);
    if (mhl_hit) begin
      second_cls = cfg.mhl_supported ? ACC_MHL : ACC_UNDEF;
    end else begin
      second_cls = cfg.host_supported ? ACC_HOST : ACC_UNDEF;
    end
  end

  // Sort the first reading into its window
  always_comb begin
    if (!cfg.adc_mode || (item.id_level && !item.redetect)) begin
      cls = ACC_UNDOCKED;
    end else if (item.adc_first < ADC_SECOND_HI) begin
      cls = second_cls;
    end else if (item.adc_first < ADC_CAR_HI) begin
      cls = ACC_CAR;
    end else if (item.adc_first >= ADC_HEADSET_LO && item.adc_first < ADC_DMB_LO) begin
      cls = ACC_HEADSET;
    end else if (item.adc_first >= ADC_DMB_LO && item.adc_first < ADC_DESK_LO) begin
      cls = ACC_DMB;
    end else if (item.adc_first >= ADC_DESK_LO && item.adc_first < ADC_DESK_HI) begin
      cls = ACC_DESK;
    end else begin
      cls = ACC_UNDEF;
    end
  end

  // Run counter: restart after a settled run, count equal classes
  always_comb begin
    count_base = (state.same_count >= cfg.stable_needed) ? 4'd0 : state.same_count;
    count_nxt  = (cls == state.last_class) ? count_base + 4'd1 : 4'd0;
    retry      = cfg.adc_mode && (count_nxt < cfg.stable_needed);
  end

  // Decode actions and the next accessory state
  always_comb begin
    res     = '0;
    acc_nxt = state.current_accessory;
    case (cls)
      ACC_DESK, ACC_CAR, ACC_MHL: begin
        res.switch_update = 1'b1;
        res.switch_value  = cls;
        acc_nxt           = cls;
      end
      ACC_HEADSET: begin
        res.audio_path = AUDIO_USB_AUDIO;
        acc_nxt        = ACC_HEADSET;
      end
      ACC_HOST: begin
        res.host_notify = HOST_CONNECT;
        acc_nxt         = ACC_HOST;
      end
      ACC_DMB: begin
        res.charge_clear  = 1'b1;
        res.switch_update = 1'b1;
        res.switch_value  = ACC_DMB;
        acc_nxt           = ACC_DMB;
      end
      default: begin
        // Removal of whatever is attached; MHL keeps its accessory state
        case (state.current_accessory)
          ACC_DESK, ACC_CAR, ACC_DMB: begin
            res.switch_update = 1'b1;
            res.switch_value  = ACC_UNDOCKED;
            acc_nxt           = ACC_UNDOCKED;
          end
          ACC_HEADSET: begin
            res.audio_path = AUDIO_USB;
            acc_nxt        = ACC_UNDOCKED;
          end
          ACC_MHL: begin
            res.switch_update = 1'b1;
            res.switch_value  = ACC_UNDOCKED;
          end
          ACC_HOST: begin
            res.host_notify = HOST_DISCONNECT;
            acc_nxt         = ACC_UNDOCKED;
          end
          default: begin
          end
        endcase
      end
    endcase

    // Re-arm the ID interrupt unless MHL owns the line
    if (acc_nxt != ACC_MHL) begin
      res.irq_rearm        = 1'b1;
      res.irq_trigger_high = (acc_nxt == ACC_UNDOCKED) ? !item.id_level : 1'b1;
    end
    res.settled   = 1'b1;
    res.accessory = acc_nxt;

    // Retry reports nothing and keeps the accessory
    if (retry) begin
      res           = '0;
      res.accessory = state.current_accessory;
    end
  end

  // Next state; counter and last class move only in ADC mode
  always_comb begin
    state_nxt = state;
    if (cfg.adc_mode) begin
      state_nxt.last_class = cls;
      state_nxt.same_count = count_nxt;
    end
    if (!retry) begin
      state_nxt.current_accessory = acc_nxt;
    end
  end

endmodule
